### rtl/core/vda_pkg.sv
// ----------------------------------------------------------------------------
// vda_pkg
// Shared types and constants of the vector distance accumulator.
// ----------------------------------------------------------------------------
package vda_pkg;

    localparam int INPUT_LANES = 4;
    localparam int LANES_DEF   = 4;
    localparam int IN_W        = 16;
    localparam int VL_W        = 3;
    localparam int DIFF_W      = IN_W + 1;
    localparam int TERM_W      = 2 * DIFF_W;
    localparam int ACC_W       = 48;

    // 1.0 in Q2.28
    localparam logic [ACC_W-1:0] ONE_Q2_28 = ACC_W'(1) << 28;

    typedef enum logic {
        METRIC_L2SQ = 1'b0,
        METRIC_IP   = 1'b1
    } metric_t;

    typedef struct packed {
        logic    last;
        metric_t metric;
    } item_ctrl_t;

endpackage

### rtl/core/vector_distance_accumulate.sv
// ----------------------------------------------------------------------------
// vector_distance_accumulate
// Streaming squared Euclidean or one-minus-inner-product distance.
// ----------------------------------------------------------------------------
// Each request carries up to four Q1.14 element pairs; valid_lanes tells how
// many of the lower lanes count, and last closes the vector. The block takes
// one request per clock cycle while in_stall is low: every lane has its own
// multiplier, a merge adder folds the lane terms, and a 48-bit accumulator
// collects them. The distance (Q2.28) passes the lane and merge registers into
// an output register and waits there while the next vector already streams in.
// Write metric only between vectors, with no request in flight.
// ----------------------------------------------------------------------------
module vector_distance_accumulate
    import vda_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write_en,
    input  logic                    cfg_write_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  a_lane0,
    input  logic signed [IN_W-1:0]  a_lane1,
    input  logic signed [IN_W-1:0]  a_lane2,
    input  logic signed [IN_W-1:0]  a_lane3,
    input  logic signed [IN_W-1:0]  b_lane0,
    input  logic signed [IN_W-1:0]  b_lane1,
    input  logic signed [IN_W-1:0]  b_lane2,
    input  logic signed [IN_W-1:0]  b_lane3,
    input  logic        [VL_W-1:0]  valid_lanes,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ACC_W-1:0] distance
);

    localparam int SUM_W = TERM_W + $clog2(LANES + 1);

    metric_t                  metric_reg;
    logic                     s1_valid_reg;
    logic                     s1_valid_next;
    item_ctrl_t               s1_ctrl_reg;
    logic                     s1_ready;
    logic                     in_fire;
    logic                     merge_ready;
    logic                     take;
    logic                     s2_valid;
    item_ctrl_t               s2_ctrl;
    logic signed [SUM_W-1:0]  s2_sum;
    logic signed [IN_W-1:0]   a_arr [INPUT_LANES];
    logic signed [IN_W-1:0]   b_arr [INPUT_LANES];
    logic signed [TERM_W-1:0] terms [LANES];

    assign a_arr[0] = a_lane0;
    assign a_arr[1] = a_lane1;
    assign a_arr[2] = a_lane2;
    assign a_arr[3] = a_lane3;
    assign b_arr[0] = b_lane0;
    assign b_arr[1] = b_lane1;
    assign b_arr[2] = b_lane2;
    assign b_arr[3] = b_lane3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg <= METRIC_L2SQ;
        end
        else if (cfg_write_en)
        begin
            metric_reg <= metric_t'(cfg_write_data);
        end
    end

    assign s1_ready = !s1_valid_reg || merge_ready;
    assign in_stall = !s1_ready;
    assign in_fire  = in_valid && s1_ready;

    always_comb
    begin
        if (s1_ready)
        begin
            s1_valid_next = in_valid;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // capture the metric with the request so the final distance step follows its own setting
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ctrl_reg.last   <= last;
            s1_ctrl_reg.metric <= metric_reg;
        end
    end

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        vda_lane u_lane (
            .clk    (clk),
            .load   (in_fire),
            .metric (metric_reg),
            .active (valid_lanes > VL_W'(i)),
            .a      (a_arr[i]),
            .b      (b_arr[i]),
            .term   (terms[i])
        );
    end

    vda_merge #(
        .LANES (LANES)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ctrl   (s1_ctrl_reg),
        .terms     (terms),
        .ready     (merge_ready),
        .take      (take),
        .sum_valid (s2_valid),
        .sum_ctrl  (s2_ctrl),
        .sum       (s2_sum)
    );

    vda_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .sum_valid (s2_valid),
        .sum_ctrl  (s2_ctrl),
        .sum       (s2_sum),
        .take      (take),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .distance  (distance)
    );

    a_stall_means_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && s2_valid)
        else $error("input stalled with room in the pipeline");

    a_take_needs_data : assert property (@(posedge clk) disable iff (!rst_n)
        take |-> s2_valid)
        else $error("accumulator took an empty stage");

endmodule

### rtl/core/vda_lane.sv
// ----------------------------------------------------------------------------
// vda_lane
// One element lane: squared difference or product of a pair, registered.
// ----------------------------------------------------------------------------
module vda_lane
    import vda_pkg::*;
(
    input  logic                     clk,
    input  logic                     load,
    input  metric_t                  metric,
    input  logic                     active,
    input  logic signed [IN_W-1:0]   a,
    input  logic signed [IN_W-1:0]   b,
    output logic signed [TERM_W-1:0] term
);

    logic signed [DIFF_W-1:0] diff;
    logic signed [DIFF_W-1:0] op_x;
    logic signed [DIFF_W-1:0] op_y;
    logic signed [TERM_W-1:0] prod;
    logic signed [TERM_W-1:0] term_next;
    logic signed [TERM_W-1:0] term_reg;

    assign diff = DIFF_W'(a) - DIFF_W'(b);

    always_comb
    begin
        unique case (metric)
            METRIC_L2SQ:
            begin
                op_x = diff;
                op_y = diff;
            end
            METRIC_IP:
            begin
                op_x = DIFF_W'(a);
                op_y = DIFF_W'(b);
            end
            default:
            begin
                op_x = diff;
                op_y = diff;
            end
        endcase
    end

    // keep the product in its own signed context
    assign prod = op_x * op_y;

    // unused lanes contribute nothing
    assign term_next = active ? prod : '0;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

### rtl/core/vda_merge.sv
// ----------------------------------------------------------------------------
// vda_merge
// Adds the lane terms of one item into a single registered partial sum.
// ----------------------------------------------------------------------------
module vda_merge
    import vda_pkg::*;
#(
    parameter int LANES = LANES_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  item_ctrl_t               in_ctrl,
    input  logic signed [TERM_W-1:0] terms [LANES],
    output logic                     ready,
    input  logic                     take,
    output logic                     sum_valid,
    output item_ctrl_t               sum_ctrl,
    output logic signed [TERM_W+$clog2(LANES+1)-1:0] sum
);

    localparam int SUM_W = TERM_W + $clog2(LANES + 1);

    logic                    valid_reg;
    logic                    valid_next;
    item_ctrl_t              ctrl_reg;
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic                    load;

    assign ready = !valid_reg || take;
    assign load  = in_valid && ready;

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            sum_next = sum_next + SUM_W'(terms[i]);
        end
    end

    always_comb
    begin
        if (ready)
        begin
            valid_next = in_valid;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg  <= sum_next;
            ctrl_reg <= in_ctrl;
        end
    end

    assign sum_valid = valid_reg;
    assign sum_ctrl  = ctrl_reg;
    assign sum       = sum_reg;

    a_hold_until_taken : assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !take |=> valid_reg && $stable(sum_reg) && $stable(ctrl_reg))
        else $error("partial sum changed before it was taken");

endmodule

### rtl/core/vda_accum.sv
// ----------------------------------------------------------------------------
// vda_accum
// Running 48-bit sum and the output register for the finished distance.
// ----------------------------------------------------------------------------
module vda_accum
    import vda_pkg::*;
#(
    parameter int SUM_W = TERM_W + 3
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sum_valid,
    input  item_ctrl_t              sum_ctrl,
    input  logic signed [SUM_W-1:0] sum,
    output logic                    take,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [ACC_W-1:0] distance
);

    logic             [ACC_W-1:0] running_sum_reg;
    logic             [ACC_W-1:0] running_sum_next;
    logic             [ACC_W-1:0] acc_new;
    logic             [ACC_W-1:0] dist_reg;
    logic             [ACC_W-1:0] dist_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_free;
    logic                         out_fire;

    assign out_fire = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || !out_stall;
    // a non-final request only touches the running sum
    assign take     = sum_valid && (!sum_ctrl.last || out_free);
    assign acc_new  = running_sum_reg + ACC_W'(sum);

    always_comb
    begin
        running_sum_next = running_sum_reg;
        dist_next        = dist_reg;
        out_valid_next   = out_valid_reg && !out_fire;
        if (take)
        begin
            if (sum_ctrl.last)
            begin
                running_sum_next = '0;
                out_valid_next   = 1'b1;
                unique case (sum_ctrl.metric)
                    METRIC_L2SQ: dist_next = acc_new;
                    METRIC_IP:   dist_next = ONE_Q2_28 - acc_new;
                    default:     dist_next = acc_new;
                endcase
            end
            else
            begin
                running_sum_next = acc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            running_sum_reg <= running_sum_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
    end

    assign out_valid = out_valid_reg;
    assign distance  = $signed(dist_reg);

    a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        take && sum_ctrl.last |=> running_sum_reg == '0)
        else $error("running sum not cleared after final request");

    a_result_after_last : assert property (@(posedge clk) disable iff (!rst_n)
        take && sum_ctrl.last |=> out_valid_reg)
        else $error("final request produced no distance");

    a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(take && sum_ctrl.last))
        else $error("pending distance overwritten");

endmodule
